// File: rtl/gfcfb_pkg.sv
// ----------------------------------------------------------------------------
// gfcfb_pkg
// Shared types, constants and GF(2^4) helpers for the CFB encrypt block.
// ----------------------------------------------------------------------------
package gfcfb_pkg;

  localparam int ROUND_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROUND_W-1:0]   LAST_ROUND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IV     = 2'd1;

  // Fixed mix matrix [[3,7],[4,3]]
  localparam logic [3:0] MIX00 = 4'h3;
  localparam logic [3:0] MIX01 = 4'h7;
  localparam logic [3:0] MIX10 = 4'h4;
  localparam logic [3:0] MIX11 = 4'h3;

  // Controller to datapath commands
  typedef struct packed {
    logic               load;
    logic               step;
    logic               finish;
    logic [ROUND_W-1:0] round;
  } gfcfb_cmd_t;

  // Multiply in GF(2^4) modulo x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = aa[3] ? ({aa[2:0], 1'b0} ^ 4'h3) : {aa[2:0], 1'b0};
    end
    return acc;
  endfunction

  // Field inverse, zero maps to zero
  function automatic logic [3:0] gf_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h1: y = 4'h1;
      4'h2: y = 4'h9;
      4'h3: y = 4'he;
      4'h4: y = 4'hd;
      4'h5: y = 4'hb;
      4'h6: y = 4'h7;
      4'h7: y = 4'h6;
      4'h8: y = 4'hf;
      4'h9: y = 4'h2;
      4'ha: y = 4'hc;
      4'hb: y = 4'h5;
      4'hc: y = 4'ha;
      4'hd: y = 4'h4;
      4'he: y = 4'h3;
      4'hf: y = 4'h8;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // Inverse followed by the affine map
  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    y = gf_inv(x);
    return {~(y[1] ^ y[2] ^ y[3]), ^y, y[0] ^ y[1], ~y[0]};
  endfunction

  // Key byte to round-key nibble: hi*lo ^ hi ^ lo
  function automatic logic [3:0] word_nibble(input logic [7:0] w);
    return gf_mul(w[7:4], w[3:0]) ^ w[7:4] ^ w[3:0];
  endfunction

  // Key schedule round constant, indexed by the round being prepared
  function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
    logic [7:0] c;
    case (r)
      3'd1: c = 8'h03;
      3'd2: c = 8'h06;
      3'd3: c = 8'h0c;
      3'd4: c = 8'h0b;
      3'd5: c = 8'h05;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/gfcfb_ctrl.sv
// ----------------------------------------------------------------------------
// gfcfb_ctrl
// Sequencer: load cycle, six rounds, output register handshake.
// ----------------------------------------------------------------------------
module gfcfb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gfcfb_pkg::gfcfb_cmd_t  cmd
);
  import gfcfb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic               state_next;
  logic [ROUND_W-1:0] round;
  logic [ROUND_W-1:0] round_next;
  logic               out_valid_next;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    round_next     = round;
    cmd            = '0;
    cmd.round      = round;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          round_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (round == LAST_ROUND) begin
          // hold the last round until the output register frees up
          if (out_free) begin
            cmd.finish     = 1'b1;
            out_valid_next = 1'b1;
            round_next     = '0;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          round_next = round + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
        round_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      round     <= round_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_RUN) && (round == '0))
    else $error("load did not start round 0");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished beat not presented");

  a_idle_round_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (round == '0))
    else $error("round counter not cleared in idle");

  a_finish_only_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (state == ST_RUN) && (round == LAST_ROUND) && out_free)
    else $error("finish outside last round");

endmodule

// File: rtl/gfcfb_dp.sv
// ----------------------------------------------------------------------------
// gfcfb_dp
// Datapath: config registers, feedback, Feistel round and key schedule.
// ----------------------------------------------------------------------------
module gfcfb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gfcfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic [31:0]                       plain_block,
  input  logic                              restart,
  input  gfcfb_pkg::gfcfb_cmd_t             cmd,
  output logic [31:0]                       cipher_block
);
  import gfcfb_pkg::*;

  logic [31:0] key;
  logic [31:0] init_vector;
  logic [31:0] feedback;
  logic [31:0] plain;
  logic [15:0] left;
  logic [15:0] right;
  logic [7:0]  w0, w1, w2, w3;

  logic [3:0]  s00, s10, s01, s11;
  logic [3:0]  k00, k10, k01, k11;
  logic [3:0]  m00, m10, m01, m11;
  logic [3:0]  x00, x10, x01, x11;
  logic [15:0] f;
  logic [15:0] right_next;
  logic [7:0]  t_rot, t_sub;
  logic [7:0]  w0_next, w1_next, w2_next, w3_next;
  logic [31:0] fb_sel;
  logic [31:0] cipher_next;

  // round function
  always_comb begin
    s00 = sbox(right[15:12]);
    s10 = sbox(right[11:8]);
    s01 = sbox(right[7:4]);
    s11 = sbox(right[3:0]);
    k00 = word_nibble(w0);
    k10 = word_nibble(w1);
    k01 = word_nibble(w2);
    k11 = word_nibble(w3);
    m00 = gf_mul(k00, s00) ^ gf_mul(k01, s10);
    m01 = gf_mul(k00, s01) ^ gf_mul(k01, s11);
    m10 = gf_mul(k10, s00) ^ gf_mul(k11, s10);
    m11 = gf_mul(k10, s01) ^ gf_mul(k11, s11);
    x00 = gf_mul(MIX00, m00) ^ gf_mul(MIX01, m10);
    x01 = gf_mul(MIX00, m01) ^ gf_mul(MIX01, m11);
    x10 = gf_mul(MIX10, m00) ^ gf_mul(MIX11, m10);
    x11 = gf_mul(MIX10, m01) ^ gf_mul(MIX11, m11);
    // row 1 entries swapped
    f          = {x00, x11, x01, x10};
    right_next = left ^ f;
  end

  // key schedule step toward the next round
  always_comb begin
    t_rot   = {w3[4:0], w3[7:5]};
    t_sub   = {sbox(t_rot[7:4]), sbox(t_rot[3:0])} ^ rcon(cmd.round + 1'b1);
    w0_next = w0 ^ t_sub;
    w1_next = w1 ^ w0_next;
    w2_next = w2 ^ w1_next;
    w3_next = w3 ^ w2_next;
  end

  assign fb_sel      = restart ? init_vector : feedback;
  assign cipher_next = {right_next, right} ^ plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      init_vector <= '0;
      feedback    <= '0;
    end else begin
      if (cfg_write && (cfg_index == CFG_KEY)) key <= cfg_data;
      if (cfg_write && (cfg_index == CFG_IV))  init_vector <= cfg_data;
      if (cmd.finish) feedback <= cipher_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      plain <= plain_block;
      left  <= fb_sel[31:16];
      right <= fb_sel[15:0];
      w0    <= key[31:24];
      w1    <= key[23:16];
      w2    <= key[15:8];
      w3    <= key[7:0];
    end else if (cmd.step) begin
      left  <= right;
      right <= right_next;
      w0    <= w0_next;
      w1    <= w1_next;
      w2    <= w2_next;
      w3    <= w3_next;
    end
    if (cmd.finish) cipher_block <= cipher_next;
  end

endmodule

// File: rtl/gf16_feistel_cfb_encrypt_top.sv
// ----------------------------------------------------------------------------
// gf16_feistel_cfb_encrypt_top
// CFB-mode encryptor around a 6-round GF(2^4) Feistel cipher, 32-bit blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: pulse cfg_write with cfg_index 0 (key) or 1 (init vector)
//   and cfg_data; write only while the block is idle. Other indexes are
//   dropped.
//   Input channel: in_valid/in_stall carry plain_block and restart. A beat
//   with restart set encrypts the init vector instead of the last
//   ciphertext. in_stall is high while a block is in the rounds.
//   Output channel: out_valid/out_stall carry cipher_block, which also
//   becomes the feedback for the next block.
//   Timing: a load cycle, then one round per cycle through the shared
//   round unit, the last round held until the output register frees up.
//   No new beat is taken until the current block has left the rounds;
//   the CFB feedback loop through the round unit sets that limit.
//   Stall: the output register holds its beat while out_stall is high; the
//   next block may load and run meanwhile and waits in its last round until
//   the output register frees up.
//   Reset: rst clears key, init vector and feedback to zero and empties
//   both channels.
// ----------------------------------------------------------------------------
module gf16_feistel_cfb_encrypt_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gfcfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     plain_block,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     cipher_block
);
  import gfcfb_pkg::*;

  gfcfb_cmd_t cmd;

  // sequencer: owns the round count and both handshakes
  gfcfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: round unit, key schedule, feedback and output register
  gfcfb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .plain_block  (plain_block),
    .restart      (restart),
    .cmd          (cmd),
    .cipher_block (cipher_block)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GF(2^4) Feistel CFB encryptor. An in-bench
// model of the cipher and the feedback chain predicts each ciphertext beat;
// directed blocks cover the reset feedback, key and IV extremes and dropped
// register writes, then random traffic runs under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;

  import gfcfb_pkg::*;

  // Register indexes past the init vector; the block must drop writes to them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Key schedule round constants, byte r belongs to round r
  localparam logic [47:0] KS_RCON = {8'h05, 8'h0b, 8'h0c, 8'h06, 8'h03, 8'h00};

  // Mix matrix [[3,7],[4,3]]
  localparam logic [3:0] MX_A = 4'h3;
  localparam logic [3:0] MX_B = 4'h7;
  localparam logic [3:0] MX_C = 4'h4;

  localparam int  DRAIN_SLACK   = 10;
  localparam int  RANDOM_BLOCKS = 475;        // per idling phase, four phases
  localparam real TIMEOUT_NS    = 5_000_000.0;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_write    = 1'b0;
  logic [1:0]  cfg_index    = CFG_KEY;
  logic [31:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [31:0] plain_block  = '0;
  logic        restart      = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] cipher_block;

  // Predictor copies of the registers and the feedback chain
  logic [31:0] key_shadow   = '0;
  logic [31:0] iv_shadow    = '0;
  logic [31:0] chain_fb     = '0;

  logic [31:0] cipher_expect_q[$];
  logic [31:0] cipher_want;
  int          errors         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  always #5 clk = ~clk;

  gf16_feistel_cfb_encrypt_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .plain_block  (plain_block),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_block (cipher_block)
  );

  // --------------------------------------------------------------------------
  // Cipher model
  // --------------------------------------------------------------------------

  // Carry-less product, then fold the high terms back with x^4 = x + 1
  function automatic logic [3:0] gf4_mult(input logic [3:0] a, input logic [3:0] b);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 4; i++)
      if (b[i]) p = p ^ ({3'b000, a} << i);
    for (int i = 6; i >= 4; i--)
      if (p[i]) p = p ^ (7'b0010011 << (i - 4));
    return p[3:0];
  endfunction

  // Inverse by search; zero has none and stays zero
  function automatic logic [3:0] gf4_recip(input logic [3:0] x);
    logic [3:0] r;
    r = '0;
    for (int j = 1; j < 16; j++)
      if (gf4_mult(x, 4'(j)) == 4'h1) r = 4'(j);
    return r;
  endfunction

  function automatic logic [3:0] nib_sub(input logic [3:0] x);
    logic [3:0] y;
    logic [3:0] z;
    y    = gf4_recip(x);
    z[0] = ~y[0];
    z[1] = y[0] ^ y[1];
    z[2] = y[0] ^ y[1] ^ y[2] ^ y[3];
    z[3] = ~(y[1] ^ y[2] ^ y[3]);
    return z;
  endfunction

  function automatic logic [3:0] key_nibble(input logic [7:0] w);
    return gf4_mult(w[7:4], w[3:0]) ^ w[7:4] ^ w[3:0];
  endfunction

  // Six Feistel rounds; output is the final right half, then the left half
  function automatic logic [31:0] feistel_encrypt(input logic [31:0] blk,
                                                  input logic [31:0] k);
    logic [7:0]  w  [4];
    logic [7:0]  t;
    logic [3:0]  rk [6][2][2];
    logic [3:0]  s  [2][2];
    logic [3:0]  m  [2][2];
    logic [3:0]  x00, x01, x10, x11;
    logic [15:0] lh, rh, f, nr;
    w[0] = k[31:24];
    w[1] = k[23:16];
    w[2] = k[15:8];
    w[3] = k[7:0];
    for (int r = 0; r < 6; r++) begin
      if (r > 0) begin
        t    = {w[3][4:0], w[3][7:5]};
        t    = {nib_sub(t[7:4]), nib_sub(t[3:0])} ^ KS_RCON[r*8 +: 8];
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
      end
      rk[r][0][0] = key_nibble(w[0]);
      rk[r][1][0] = key_nibble(w[1]);
      rk[r][0][1] = key_nibble(w[2]);
      rk[r][1][1] = key_nibble(w[3]);
    end
    lh = blk[31:16];
    rh = blk[15:0];
    for (int r = 0; r < 6; r++) begin
      s[0][0] = nib_sub(rh[15:12]);
      s[1][0] = nib_sub(rh[11:8]);
      s[0][1] = nib_sub(rh[7:4]);
      s[1][1] = nib_sub(rh[3:0]);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          m[i][j] = gf4_mult(rk[r][i][0], s[0][j]) ^ gf4_mult(rk[r][i][1], s[1][j]);
      x00 = gf4_mult(MX_A, m[0][0]) ^ gf4_mult(MX_B, m[1][0]);
      x01 = gf4_mult(MX_A, m[0][1]) ^ gf4_mult(MX_B, m[1][1]);
      x10 = gf4_mult(MX_C, m[0][0]) ^ gf4_mult(MX_A, m[1][0]);
      x11 = gf4_mult(MX_C, m[0][1]) ^ gf4_mult(MX_A, m[1][1]);
      // row 1 is swapped before packing
      f  = {x00, x11, x01, x10};
      nr = lh ^ f;
      lh = rh;
      rh = nr;
    end
    return {rh, lh};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one plaintext beat, with a random gap first, and predict its cipher
  // beat at the edge it is taken.
  task automatic send_block(input logic [31:0] p, input logic r);
    logic [31:0] c;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    plain_block <= p;
    restart     <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // taken at this edge: advance the feedback chain
    c        = feistel_encrypt(r ? iv_shadow : chain_fb, key_shadow) ^ p;
    chain_fb = c;
    cipher_expect_q.push_back(c);
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // One register write; the trailing cycle keeps back-to-back writes apart
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_KEY) key_shadow = data;
    if (idx == CFG_IV)  iv_shadow  = data;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers and feedback at their reset value: chain off the zero feedback
  // before any restart, then restart from the zero IV.
  task automatic test_reset_state;
    send_block(32'h0000_0000, 1'b0);
    send_block(32'hffff_ffff, 1'b0);
    send_block(32'h0000_0000, 1'b1);
    send_block(32'h8000_0001, 1'b0);
    drain();
  endtask

  // All-ones and all-zero key and IV, both ways round
  task automatic test_key_extremes;
    write_reg(CFG_KEY, 32'hffff_ffff);
    write_reg(CFG_IV,  32'hffff_ffff);
    send_block(32'h0000_0000, 1'b1);
    send_block(32'hffff_ffff, 1'b0);
    send_block(32'h5555_aaaa, 1'b0);
    send_block(32'hffff_ffff, 1'b1);
    drain();
    write_reg(CFG_KEY, 32'h0000_0000);
    send_block(32'haaaa_5555, 1'b1);
    send_block(32'h0000_0001, 1'b0);
    drain();
    write_reg(CFG_KEY, 32'hffff_ffff);
    write_reg(CFG_IV,  32'h0000_0000);
    send_block(32'h8000_0000, 1'b1);
    send_block(32'h7fff_ffff, 1'b0);
    drain();
  endtask

  // Writes past the last register must leave key and IV alone
  task automatic test_spare_index;
    write_reg(CFG_KEY, 32'h0123_4567);
    write_reg(CFG_IV,  32'h89ab_cdef);
    write_reg(CFG_SPARE_A, 32'hdead_beef);
    write_reg(CFG_SPARE_B, 32'hffff_ffff);
    send_block(32'h1234_5678, 1'b1);
    send_block(32'h0f0f_f0f0, 1'b0);
    send_block(32'hf0f0_0f0f, 1'b1);
    drain();
  endtask

  // One phase of random traffic under a given idle/stall mix. Each phase
  // starts from fresh register values, sometimes at an extreme.
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    logic [31:0] p;
    logic [31:0] kval;
    logic [31:0] ival;
    logic [1:0]  spare;
    kval = $urandom();
    ival = $urandom();
    case ($urandom_range(0, 3))
      0: kval = 32'h0000_0000;
      1: kval = 32'hffff_ffff;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: ival = 32'h0000_0000;
      1: ival = 32'hffff_ffff;
      default: ;
    endcase
    write_reg(CFG_KEY, kval);
    write_reg(CFG_IV,  ival);
    spare = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    write_reg(spare, $urandom());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      case ($urandom_range(0, 15))
        0: p = 32'h0000_0000;
        1: p = 32'hffff_ffff;
        default: p = $urandom();
      endcase
      // restart now and then; long chains in between
      send_block(p, $urandom_range(0, 7) == 0);
      // occasional bursts of back-to-back beats even in idle phases
      if ($urandom_range(0, 49) == 0) send_idle_pct = 0;
      else if ($urandom_range(0, 19) == 0) send_idle_pct = idle_pct;
    end
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every taken cipher beat with the oldest
  // prediction, then pick the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_expect_q.size() == 0) begin
          $error("cipher_block: beat with nothing expected, actual %08h", cipher_block);
          errors++;
        end else begin
          cipher_want = cipher_expect_q.pop_front();
          if (cipher_block !== cipher_want) begin
            $error("cipher_block: expected %08h, actual %08h", cipher_want, cipher_block);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_key_extremes();
    test_spare_index();
    test_random_phase(0, 0);     // full rate both sides
    test_random_phase(68, 0);    // sparse sender
    test_random_phase(0, 68);    // stalling receiver
    test_random_phase(33, 33);   // both
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
